[rtl/core/tfb_pkg.sv]
// ----------------------------------------------------------------------------
// Telemetry frame builder package
// Shared types, constants and the CRC-32 byte step used by the front part,
// the command queue and the back part of the frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

    // Number of packet types that own a sequence counter.
    localparam int TYPE_COUNT = 8;
    localparam int TYPE_IW    = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam logic [8:0] TYPE_LIMIT = 9'(TYPE_COUNT);

    // Command queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // CRC-32, IEEE, reflected.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Configuration register indexes.
    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_TRAILER = 1'b1;

    typedef enum logic {
        CMD_BEGIN   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } t_cmd_kind;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] ptype;
        logic [7:0] seq;
        logic [7:0] len;
        logic [7:0] data;
        logic       last;   // the frame closes after this word
    } t_cmd;

    // Queue status seen by the front part.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/tfb_front.sv]
// ----------------------------------------------------------------------------
// Telemetry frame builder front part
// Accepts input words, keeps the frame and sequence bookkeeping and pushes
// classified commands into the queue. Words that produce no output are dropped.
// ----------------------------------------------------------------------------
module tfb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [7:0]           i_packet_type,
    input  logic [7:0]           i_payload_len,
    input  logic [7:0]           i_data_byte,
    input  tfb_pkg::t_q_status   i_q_status,
    output logic                 o_push,
    output tfb_pkg::t_cmd        o_push_cmd
);

    logic [7:0]                 r_seq [tfb_pkg::TYPE_COUNT];
    logic                       r_open;
    logic [7:0]                 r_remaining;
    logic                       n_open;
    logic [7:0]                 n_remaining;
    logic                       w_accept;
    logic                       w_type_ok;
    logic [tfb_pkg::TYPE_IW-1:0] w_idx;
    logic                       w_is_begin;

    assign o_ready    = !i_q_status.full;
    assign w_accept   = i_valid && o_ready;
    assign w_is_begin = (i_cmd == tfb_pkg::CMD_BEGIN);
    assign w_type_ok  = ({1'b0, i_packet_type} < tfb_pkg::TYPE_LIMIT);
    assign w_idx      = i_packet_type[tfb_pkg::TYPE_IW-1:0];

    always_comb begin
        o_push      = 1'b0;
        n_open      = r_open;
        n_remaining = r_remaining;
        o_push_cmd.kind  = w_is_begin ? tfb_pkg::CMD_BEGIN : tfb_pkg::CMD_PAYLOAD;
        o_push_cmd.ptype = i_packet_type;
        o_push_cmd.seq   = r_seq[w_idx];
        o_push_cmd.len   = i_payload_len;
        o_push_cmd.data  = i_data_byte;
        o_push_cmd.last  = 1'b0;
        if (w_is_begin) begin
            o_push_cmd.last = (i_payload_len == 8'd0);
            if (w_accept && w_type_ok) begin
                o_push      = 1'b1;
                n_open      = (i_payload_len != 8'd0);
                n_remaining = i_payload_len;
            end
        end else begin
            o_push_cmd.last = (r_remaining == 8'd1);
            if (w_accept && r_open) begin
                o_push      = 1'b1;
                n_remaining = r_remaining - 8'd1;
                if (r_remaining == 8'd1) begin
                    n_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
            for (int i = 0; i < tfb_pkg::TYPE_COUNT; i++) begin
                r_seq[i] <= 8'd0;
            end
        end else begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
            if (o_push && w_is_begin) begin
                r_seq[w_idx] <= r_seq[w_idx] + 8'd1;
            end
        end
    end

endmodule

[rtl/core/tfb_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// Telemetry frame builder command queue
// Short first-in first-out queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
module tfb_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tfb_pkg::t_cmd      i_push_cmd,
    input  logic               i_pop,
    output logic               o_valid,
    output tfb_pkg::t_cmd      o_head,
    output tfb_pkg::t_q_status o_status
);

    tfb_pkg::t_cmd            r_mem [tfb_pkg::Q_DEPTH];
    logic [tfb_pkg::Q_AW-1:0] r_wr_ptr;
    logic [tfb_pkg::Q_AW-1:0] r_rd_ptr;
    logic [tfb_pkg::Q_AW:0]   r_count;
    logic                     w_do_push;
    logic                     w_do_pop;

    assign o_status.full  = (r_count == (tfb_pkg::Q_AW+1)'(tfb_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_valid        = !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/core/tfb_back.sv]
// ----------------------------------------------------------------------------
// Telemetry frame builder back part
// Expands queued commands into frame bytes, runs the CRC one byte per cycle
// while the output is not stalled, and holds the output register.
// ----------------------------------------------------------------------------
module tfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_magic,
    input  logic [7:0]    i_trailer,
    input  logic          i_q_valid,
    input  tfb_pkg::t_cmd i_q_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_tx_byte,
    output logic          o_frame_end
);

    typedef enum logic [1:0] {
        PH_START,
        PH_HEAD,
        PH_CRC,
        PH_TRAIL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_step, n_step;
    logic [31:0] r_crc, n_crc;
    logic        r_valid;
    logic [7:0]  r_tx_byte, n_tx_byte;
    logic        r_frame_end, n_frame_end;
    logic        w_fire;
    logic [31:0] w_crc_out;

    assign w_fire    = i_q_valid && (!r_valid || i_ready);
    assign w_crc_out = ~r_crc;

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_crc       = r_crc;
        n_tx_byte   = 8'd0;
        n_frame_end = 1'b0;
        o_pop       = 1'b0;
        case (r_phase)
            PH_START: begin
                if (i_q_head.kind == tfb_pkg::CMD_BEGIN) begin
                    n_tx_byte = i_magic;
                    n_crc     = tfb_pkg::crc_byte(tfb_pkg::CRC_INIT, i_magic);
                    n_phase   = PH_HEAD;
                    n_step    = 3'd1;
                end else begin
                    n_tx_byte = i_q_head.data;
                    n_crc     = tfb_pkg::crc_byte(r_crc, i_q_head.data);
                    if (i_q_head.last) begin
                        n_phase = PH_CRC;
                        n_step  = 3'd0;
                    end else begin
                        o_pop = 1'b1;
                    end
                end
            end
            PH_HEAD: begin
                case (r_step)
                    3'd1:    n_tx_byte = i_q_head.ptype;
                    3'd2:    n_tx_byte = i_q_head.seq;
                    3'd3:    n_tx_byte = 8'd0;
                    default: n_tx_byte = i_q_head.len;
                endcase
                n_crc = tfb_pkg::crc_byte(r_crc, n_tx_byte);
                if (r_step == 3'd4) begin
                    n_step = 3'd0;
                    if (i_q_head.last) begin
                        n_phase = PH_CRC;
                    end else begin
                        n_phase = PH_START;
                        o_pop   = 1'b1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            PH_CRC: begin
                n_tx_byte = w_crc_out[{r_step[1:0], 3'b000} +: 8];
                if (r_step[1:0] == 2'd3) begin
                    n_phase = PH_TRAIL;
                    n_step  = 3'd0;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            PH_TRAIL: begin
                n_tx_byte   = i_trailer;
                n_frame_end = 1'b1;
                n_crc       = tfb_pkg::CRC_INIT;
                n_phase     = PH_START;
                o_pop       = 1'b1;
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
        if (!w_fire) begin
            o_pop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_step      <= 3'd0;
            r_crc       <= tfb_pkg::CRC_INIT;
            r_valid     <= 1'b0;
            r_tx_byte   <= 8'd0;
            r_frame_end <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase     <= n_phase;
                r_step      <= n_step;
                r_crc       <= n_crc;
                r_valid     <= 1'b1;
                r_tx_byte   <= n_tx_byte;
                r_frame_end <= n_frame_end;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_frame_end = r_frame_end;

endmodule

[rtl/core/telemetry_frame_builder.sv]
// ----------------------------------------------------------------------------
// Telemetry frame builder
// Turns begin and payload words into length-prefixed serial frames closed by
// a CRC-32 and a trailer byte, one frame byte per output word.
// ----------------------------------------------------------------------------
// A begin word of a known packet type produces five header bytes (magic byte,
// type, that type's sequence number, a zero byte and the payload length), and
// each payload word of an open frame produces its own byte; the last payload
// byte, or the header itself when the length is zero, is followed by the four
// CRC bytes, least significant first, and the trailer byte flagged by
// o_frame_end. The CRC is the IEEE reflected CRC-32 over header and payload.
// Begin words of an unknown type and payload words outside a frame are taken
// and dropped, and a new begin abandons an open frame without closing it.
// The front part classifies each input word in the cycle it is accepted and
// places it in a four-entry command queue; the back part then emits one byte
// per cycle, while the output is not stalled, into an output register, so a
// payload word yields one byte, a begin word five, and a word that closes the
// frame five more. The input keeps being accepted while the back part drains
// a header or a CRC until the queue is full; a byte reaches the output only
// after its word has passed through the command queue and the output register.
// The magic and trailer registers lie at byte addresses 0 and 4 of the APB port
// and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module telemetry_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_packet_type,
    input  logic [7:0]  i_payload_len,
    input  logic [7:0]  i_data_byte,
    // Output words.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_end
);

    logic [7:0]         r_magic;
    logic [7:0]         r_trailer;
    logic               w_cfg_write;
    logic               w_push;
    tfb_pkg::t_cmd      w_push_cmd;
    logic               w_pop;
    logic               w_q_valid;
    tfb_pkg::t_cmd      w_q_head;
    tfb_pkg::t_q_status w_q_status;

    // The register index is the word address; byte offsets within a word are ignored.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= 8'd0;
            r_trailer <= 8'd0;
        end else if (w_cfg_write) begin
            if (paddr[2] == tfb_pkg::REG_MAGIC) begin
                r_magic <= pwdata[7:0];
            end else begin
                r_trailer <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == tfb_pkg::REG_TRAILER) begin
            prdata = {24'd0, r_trailer};
        end else begin
            prdata = {24'd0, r_magic};
        end
    end

    tfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_packet_type (i_packet_type),
        .i_payload_len (i_payload_len),
        .i_data_byte   (i_data_byte),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_push_cmd    (w_push_cmd)
    );

    tfb_cmd_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_head     (w_q_head),
        .o_status   (w_q_status)
    );

    tfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_magic     (r_magic),
        .i_trailer   (r_trailer),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

endmodule
